FILE: hw/rtl/ppg_pkg.sv
// ppg_pkg: shared types and constants of the pulse-sensor register model
// operation codes, register map, waveform constants, control/status structs
// no dependencies
package ppg_pkg;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_START = 2'd1,
		OP_WRITE = 2'd2,
		OP_READ  = 2'd3
	} op_t;

	localparam int OP_W = 2;
	localparam int BYTE_W = 8;

	// register map
	localparam logic [7:0] REG_STATUS   = 8'h00;
	localparam logic [7:0] REG_WR_PTR   = 8'h04;
	localparam logic [7:0] REG_RD_PTR   = 8'h06;
	localparam logic [7:0] REG_DATA     = 8'h07;
	localparam logic [7:0] REG_FIFO_CFG = 8'h08;
	localparam logic [7:0] REG_REV_ID   = 8'hFE;
	localparam logic [7:0] REG_PART_ID  = 8'hFF;

	localparam logic [7:0] PART_ID     = 8'h15;
	localparam logic [7:0] REV_ID      = 8'h03;
	localparam logic [7:0] STATUS_RDY  = 8'h40;

	// synthetic waveform
	localparam logic [15:0] PHASE_STEP = 16'd3146;
	localparam logic [15:0] IR_OFFSET  = 16'd3129;
	localparam logic [15:0] RED_BASE   = 16'd50000;
	localparam logic [15:0] IR_BASE    = 16'd45000;
	localparam logic [13:0] RED_AMP    = 14'd8000;
	localparam logic [13:0] IR_AMP     = 14'd9000;
	localparam logic [15:0] HALF_TURN  = 16'h8000;

	// sine quotient: q = 8ab * 2^31 / (5 * 2^30 - 4ab), q < 2^31
	localparam int AB_W   = 29;
	localparam int DEN_W  = 33;
	localparam int QUO_W  = 31;
	localparam int AMP_W  = 14;
	localparam int PROD_W = AMP_W + QUO_W;
	localparam int FRAC_W = 30;
	localparam logic [DEN_W-1:0] DEN_BASE = 33'h1_4000_0000;
	localparam int DIV_STEPS = QUO_W;
	localparam int CNT_W = 5;

	typedef struct packed {
		logic capture;
		logic load_ab;
		logic div_init;
		logic div_step;
		logic scale;
		logic commit;
	} ppg_cmd_t;

	typedef struct packed {
		logic stream_sel;
		logic out_free;
	} ppg_status_t;

endpackage

FILE: hw/rtl/ppg_req_if.sv
// ppg_req_if: request channel carrying one bus or timer event per item
// depends on ppg_pkg
interface ppg_req_if import ppg_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   op;
	logic [BYTE_W-1:0] data;

	modport source (output valid, output op, output data, input ready);
	modport sink (input valid, input op, input data, output ready);
endinterface

FILE: hw/rtl/ppg_rsp_if.sv
// ppg_rsp_if: response channel carrying the read byte and interrupt level
// depends on ppg_pkg
interface ppg_rsp_if import ppg_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] read_data;
	logic              int_n;

	modport source (output valid, output read_data, output int_n, input ready);
	modport sink (input valid, input read_data, input int_n, output ready);
endinterface

FILE: hw/rtl/ppg_ctrl.sv
// ppg_ctrl: sequencer for item capture, sine evaluation and commit
// depends on ppg_pkg
module ppg_ctrl import ppg_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  ppg_status_t status,
	output ppg_cmd_t    cmd
);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_PROD  = 6'b000010,
		ST_SETUP = 6'b000100,
		ST_DIV   = 6'b001000,
		ST_SCALE = 6'b010000,
		ST_DONE  = 6'b100000
	} state_t;

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;

	always_comb begin
		state_d    = state_q;
		cnt_d      = cnt_q;
		cmd        = '0;
		item_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					cmd.capture = 1'b1;
					state_d = status.stream_sel ? ST_PROD : ST_DONE;
				end
			end
			ST_PROD: begin
				cmd.load_ab = 1'b1;
				state_d = ST_SETUP;
			end
			ST_SETUP: begin
				cmd.div_init = 1'b1;
				cnt_d = '0;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
					state_d = ST_SCALE;
				end
			end
			ST_SCALE: begin
				cmd.scale = 1'b1;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (status.out_free) begin
					cmd.commit = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule

FILE: hw/rtl/ppg_dp.sv
// ppg_dp: register file, tick timer, sine divider and response register
// depends on ppg_pkg; driven by ppg_ctrl commands
module ppg_dp import ppg_pkg::*; #(
	parameter int FIFO_DEPTH  = 32,
	parameter int MAX_AVERAGE = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [OP_W-1:0]   item_op,
	input  logic [BYTE_W-1:0] item_data,
	input  ppg_cmd_t          cmd,
	output ppg_status_t       status,
	input  logic              rsp_ready,
	output logic              rsp_valid,
	output logic [BYTE_W-1:0] rsp_read_data,
	output logic              rsp_int_n
);

	localparam int IW = $clog2(FIFO_DEPTH);
	localparam int TW = $clog2(MAX_AVERAGE + 1);

	// architectural state
	logic [7:0]    ptr_q, ptr_d;
	logic          loaded_q, loaded_d;
	logic [IW-1:0] widx_q, widx_d;
	logic [IW-1:0] ridx_q, ridx_d;
	logic [15:0]   phase_q, phase_d;
	logic          irq_q, irq_d;
	logic [7:0]    fifo_q, fifo_d;
	logic [2:0]    bpos_q, bpos_d;
	logic [TW-1:0] tick_q, tick_d;

	// item and arithmetic registers
	op_t              op_q;
	logic [7:0]       data_q;
	logic [AB_W-1:0]  ab_q;
	logic             neg_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [QUO_W-1:0] quo_q;
	logic [AMP_W-1:0] m_q;

	logic          out_valid_q;
	logic [7:0]    rd_q, rd_d;
	logic          int_n_q;

	// waveform operand selection
	logic             red;
	logic [15:0]      q_sel, a_val, b_val;
	logic [31:0]      ab_full;
	logic [AMP_W-1:0] amp;
	logic [PROD_W-1:0] prod;
	logic [DEN_W:0]   r2, diff;
	logic [15:0]      wave;

	// timer
	logic [7:0]    pow2, period;
	logic [TW-1:0] tick_inc;
	logic          sample;

	assign red     = (bpos_q < 3'd3);
	assign q_sel   = red ? phase_q : phase_q + IR_OFFSET;
	assign a_val   = q_sel[15] ? (~q_sel + 16'd1) : q_sel;
	assign b_val   = HALF_TURN - a_val;
	assign ab_full = 32'(a_val) * 32'(b_val);
	assign amp     = red ? RED_AMP : IR_AMP;
	assign prod    = PROD_W'(amp) * PROD_W'(quo_q);
	assign r2      = {rem_q, 1'b0};
	assign diff    = r2 - {1'b0, den_q};
	assign wave    = neg_q ? (red ? RED_BASE : IR_BASE) - 16'(m_q)
	                       : (red ? RED_BASE : IR_BASE) + 16'(m_q);

	assign pow2     = 8'd1 << fifo_q[7:5];
	assign period   = (pow2 > 8'(MAX_AVERAGE)) ? 8'(MAX_AVERAGE) : pow2;
	assign tick_inc = tick_q + 1'b1;

	assign status.stream_sel = (op_t'(item_op) == OP_READ) && (ptr_q == REG_DATA);
	assign status.out_free   = !out_valid_q || rsp_ready;

	always_comb begin
		ptr_d    = ptr_q;
		loaded_d = loaded_q;
		widx_d   = widx_q;
		ridx_d   = ridx_q;
		phase_d  = phase_q;
		irq_d    = irq_q;
		fifo_d   = fifo_q;
		bpos_d   = bpos_q;
		tick_d   = tick_q;
		rd_d     = '0;
		sample   = 1'b0;
		unique case (op_q)
			OP_TICK: begin
				if (8'(tick_inc) >= period) begin
					tick_d = '0;
					sample = 1'b1;
				end else begin
					tick_d = tick_inc;
				end
			end
			OP_START: begin
				loaded_d = 1'b0;
			end
			OP_WRITE: begin
				if (!loaded_q) begin
					ptr_d    = data_q;
					loaded_d = 1'b1;
				end else begin
					if (ptr_q == REG_FIFO_CFG) begin
						fifo_d = data_q;
						tick_d = '0;
					end
					ptr_d = ptr_q + 8'd1;
				end
			end
			OP_READ: begin
				unique case (ptr_q)
					REG_PART_ID:  rd_d = PART_ID;
					REG_REV_ID:   rd_d = REV_ID;
					REG_WR_PTR:   rd_d = 8'(widx_q);
					REG_RD_PTR:   rd_d = 8'(ridx_q);
					REG_FIFO_CFG: rd_d = fifo_q;
					REG_STATUS: begin
						rd_d  = irq_q ? STATUS_RDY : 8'h00;
						irq_d = 1'b0;
					end
					REG_DATA: begin
						unique case (bpos_q)
							3'd1, 3'd4: rd_d = wave[15:8];
							3'd2, 3'd5: rd_d = wave[7:0];
							default:    rd_d = 8'h00;
						endcase
						if (bpos_q >= 3'd5) begin
							bpos_d = '0;
							ridx_d = (ridx_q == IW'(FIFO_DEPTH - 1)) ? '0 : ridx_q + 1'b1;
						end else begin
							bpos_d = bpos_q + 3'd1;
						end
					end
					default: rd_d = 8'h00;
				endcase
			end
			default: rd_d = 8'h00;
		endcase
		if (sample) begin
			widx_d  = (widx_q == IW'(FIFO_DEPTH - 1)) ? '0 : widx_q + 1'b1;
			phase_d = phase_q + PHASE_STEP;
			irq_d   = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q       <= '0;
			loaded_q    <= 1'b0;
			widx_q      <= '0;
			ridx_q      <= '0;
			phase_q     <= '0;
			irq_q       <= 1'b0;
			fifo_q      <= '0;
			bpos_q      <= '0;
			tick_q      <= '0;
			out_valid_q <= 1'b0;
			int_n_q     <= 1'b1;
		end else begin
			if (cmd.commit) begin
				ptr_q       <= ptr_d;
				loaded_q    <= loaded_d;
				widx_q      <= widx_d;
				ridx_q      <= ridx_d;
				phase_q     <= phase_d;
				irq_q       <= irq_d;
				fifo_q      <= fifo_d;
				bpos_q      <= bpos_d;
				tick_q      <= tick_d;
				out_valid_q <= 1'b1;
				int_n_q     <= !irq_d;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q   <= op_t'(item_op);
			data_q <= item_data;
		end
		if (cmd.load_ab) begin
			ab_q  <= ab_full[AB_W-1:0];
			neg_q <= q_sel[15];
		end
		if (cmd.div_init) begin
			rem_q <= {1'b0, ab_q, 3'b000};
			den_q <= DEN_BASE - {2'b00, ab_q, 2'b00};
			quo_q <= '0;
		end else if (cmd.div_step) begin
			if (!diff[DEN_W]) begin
				rem_q <= diff[DEN_W-1:0];
				quo_q <= {quo_q[QUO_W-2:0], 1'b1};
			end else begin
				rem_q <= r2[DEN_W-1:0];
				quo_q <= {quo_q[QUO_W-2:0], 1'b0};
			end
		end
		if (cmd.scale) begin
			m_q <= prod[FRAC_W+AMP_W-1:FRAC_W];
		end
		if (cmd.commit) begin
			rd_q <= rd_d;
		end
	end

	assign rsp_valid     = out_valid_q;
	assign rsp_read_data = rd_q;
	assign rsp_int_n     = int_n_q;

endmodule

FILE: hw/rtl/ppg_sensor_register_model.sv
// ppg_sensor_register_model: top level of the pulse-sensor register model
// depends on ppg_pkg, ppg_req_if, ppg_rsp_if, ppg_ctrl, ppg_dp
//
// usage
// req carries one event per item: op (tick, write start, written byte,
// byte read) and data; rsp returns one item per request with the byte
// read (zero for other ops) and the interrupt pin level after the event
// an item is taken when valid and ready are both high on a rising edge
// ticks, transaction starts, writes and register reads: the result is
// registered from the done state once the output register is free
// reads of the data register evaluate the sine through a restoring
// divider at one quotient bit a cycle: product, setup, 31 divide steps,
// scale and commit, in that order, and no new item is taken until that
// commit is done
// one item is in flight at a time; the next item is accepted while the
// previous result still waits in the output register
// if rsp stalls, the finished item holds its commit until the output
// register is free, and no further item is accepted meanwhile
// reset clears the architectural state, pointers and output valid; the interrupt pin is high
module ppg_sensor_register_model import ppg_pkg::*; #(
	parameter int FIFO_DEPTH  = 32,
	parameter int MAX_AVERAGE = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	ppg_req_if.sink   req,
	ppg_rsp_if.source rsp
);

	ppg_cmd_t    cmd;
	ppg_status_t status;

	ppg_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (req.valid),
		.item_ready (req.ready),
		.status     (status),
		.cmd        (cmd)
	);

	ppg_dp #(
		.FIFO_DEPTH  (FIFO_DEPTH),
		.MAX_AVERAGE (MAX_AVERAGE)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_op       (req.op),
		.item_data     (req.data),
		.cmd           (cmd),
		.status        (status),
		.rsp_ready     (rsp.ready),
		.rsp_valid     (rsp.valid),
		.rsp_read_data (rsp.read_data),
		.rsp_int_n     (rsp.int_n)
	);

endmodule

FILE: sim/tb_ppg_sensor_register_model.sv
`timescale 1ns / 100ps
// tb_ppg_sensor_register_model: self-checking bench for the pulse-sensor register model
// drives bus and tick events, predicts every response in step, stalls both sides
// depends on ppg_pkg, ppg_req_if, ppg_rsp_if and ppg_sensor_register_model
module tb_ppg_sensor_register_model;
	import ppg_pkg::*;

	localparam int SENSOR_FIFO_DEPTH = 32;
	localparam int SENSOR_MAX_AVG    = 32;
	localparam int RANDOM_EVENTS     = 600;
	localparam int QUIET_TAIL        = 80;
	localparam int HOLD_AFTER        = 200;
	localparam int HOLD_CYCLES       = 150;
	localparam int DRAIN_CYCLES      = 60;
	localparam logic [7:0] REG_RESERVED = 8'h05;

	typedef struct packed {
		op_t        op;
		logic [7:0] data;
	} bus_event_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       int_n;
	} sensor_rsp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	ppg_req_if req ();
	ppg_rsp_if rsp ();

	ppg_sensor_register_model #(
		.FIFO_DEPTH (SENSOR_FIFO_DEPTH),
		.MAX_AVERAGE(SENSOR_MAX_AVG)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp)
	);

	bus_event_t  event_queue[$];
	sensor_rsp_t rsp_expected[$];
	bus_event_t  next_event;

	int n_sent = 0;
	int n_checked = 0;
	int errors = 0;
	int n_samples = 0;
	int n_stream_bytes = 0;
	int gap_left = 0;
	int stall_left = 0;
	int hold_left = 0;
	logic hold_done = 1'b0;

	// predicted sensor state
	logic [7:0]  ptr = '0;
	logic        ptr_loaded = 1'b0;
	int          wr_idx = 0;
	int          rd_idx = 0;
	logic [15:0] phase = '0;
	logic        irq_pending = 1'b0;
	logic [7:0]  fifo_cfg = '0;
	int          stream_pos = 0;
	int          tick_cnt = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// base + amp * sine(phase), sine by the Q30 Bhaskara approximation
	function automatic logic [23:0] wave_sample(input int unsigned base, input int unsigned amp,
			input logic [15:0] ph);
		logic neg;
		longint unsigned mag, rest, prod, num, den, quo, scaled;
		neg = ph[15];
		mag = neg ? 64'd65536 - ph : 64'(ph);
		rest = 64'd32768 - mag;
		prod = mag * rest;
		num = (prod * 16) << 30;
		den = (64'd5 << 30) - 4 * prod;
		quo = num / den;
		scaled = (amp * quo) >> 30;
		return neg ? 24'(base - scaled) : 24'(base + scaled);
	endfunction

	function automatic sensor_rsp_t predict_event(input op_t op, input logic [7:0] data);
		sensor_rsp_t r;
		logic [23:0] level;
		int unsigned period;
		r.read_data = '0;
		case (op)
			OP_TICK: begin
				period = 1 << fifo_cfg[7:5];
				if (period > SENSOR_MAX_AVG)
					period = SENSOR_MAX_AVG;
				tick_cnt++;
				if (tick_cnt >= period) begin
					tick_cnt = 0;
					wr_idx = (wr_idx + 1) % SENSOR_FIFO_DEPTH;
					phase = phase + PHASE_STEP;
					irq_pending = 1'b1;
					n_samples++;
				end
			end
			OP_START: ptr_loaded = 1'b0;
			OP_WRITE: begin
				if (!ptr_loaded) begin
					ptr = data;
					ptr_loaded = 1'b1;
				end else begin
					if (ptr == REG_FIFO_CFG) begin
						fifo_cfg = data;
						tick_cnt = 0;
					end
					ptr = ptr + 8'd1;
				end
			end
			default: begin
				case (ptr)
					REG_PART_ID:  r.read_data = PART_ID;
					REG_REV_ID:   r.read_data = REV_ID;
					REG_WR_PTR:   r.read_data = 8'(wr_idx);
					REG_RD_PTR:   r.read_data = 8'(rd_idx);
					REG_FIFO_CFG: r.read_data = fifo_cfg;
					REG_STATUS: begin
						r.read_data = irq_pending ? STATUS_RDY : 8'h00;
						irq_pending = 1'b0;
					end
					REG_DATA: begin
						if (stream_pos < 3)
							level = wave_sample(RED_BASE, RED_AMP, phase);
						else
							level = wave_sample(IR_BASE, IR_AMP, phase + IR_OFFSET);
						case (stream_pos % 3)
							0:       r.read_data = level[23:16];
							1:       r.read_data = level[15:8];
							default: r.read_data = level[7:0];
						endcase
						if (stream_pos == 5) begin
							stream_pos = 0;
							rd_idx = (rd_idx + 1) % SENSOR_FIFO_DEPTH;
						end else begin
							stream_pos++;
						end
						n_stream_bytes++;
					end
					default: r.read_data = '0;
				endcase
			end
		endcase
		r.int_n = !irq_pending;
		return r;
	endfunction

	// idle bursts only in two of every three segments and never in the tail
	function automatic logic burst_idle_ok(input int count);
		return event_queue.size() >= QUIET_TAIL && ((count >> 6) % 3) != 2;
	endfunction

	function automatic logic [7:0] pick_reg();
		case ($urandom_range(0, 9))
			0:       return REG_STATUS;
			1:       return REG_WR_PTR;
			2:       return REG_RD_PTR;
			3, 4:    return REG_DATA;
			5:       return REG_FIFO_CFG;
			6:       return REG_REV_ID;
			7:       return REG_PART_ID;
			8:       return REG_RESERVED;
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic push_event(input op_t op, input logic [7:0] d);
		bus_event_t e;
		e.op = op;
		e.data = d;
		event_queue.push_back(e);
	endtask

	task automatic select_reg(input logic [7:0] addr);
		push_event(OP_START, 8'($urandom));
		push_event(OP_WRITE, addr);
	endtask

	task automatic read_bytes(input int n);
		repeat (n) push_event(OP_READ, 8'($urandom));
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.op <= OP_TICK;
			req.data <= '0;
			gap_left <= 0;
		end else begin
			if (req.valid && req.ready) begin
				rsp_expected.push_back(predict_event(op_t'(req.op), req.data));
				n_sent++;
			end
			if (req.valid && !req.ready) begin
				req.valid <= 1'b1;
			end else if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				req.valid <= 1'b0;
			end else if (event_queue.size() > 0) begin
				if (burst_idle_ok(n_sent) && $urandom_range(0, 5) == 0) begin
					gap_left <= $urandom_range(0, 7);
					req.valid <= 1'b0;
				end else begin
					next_event = event_queue.pop_front();
					req.valid <= 1'b1;
					req.op <= next_event.op;
					req.data <= next_event.data;
				end
			end else begin
				req.valid <= 1'b0;
			end
		end
	end

	// response ready: short random stalls plus one long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			stall_left <= 0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			rsp.ready <= 1'b0;
		end else if (!hold_done && n_checked >= HOLD_AFTER) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES - 1;
			rsp.ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			rsp.ready <= 1'b0;
		end else if (burst_idle_ok(n_checked) && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 7);
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= 1'b1;
		end
	end

	// response monitor
	always @(posedge clk) begin
		sensor_rsp_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (rsp_expected.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("response %0d arrived with nothing outstanding: read_data %02h int_n %0b",
						n_checked, rsp.read_data, rsp.int_n);
			end else begin
				want = rsp_expected.pop_front();
				if (rsp.read_data !== want.read_data || rsp.int_n !== want.int_n) begin
					errors++;
					if (errors <= 10)
						$display("response %0d: expected read_data %02h int_n %0b, got read_data %02h int_n %0b",
							n_checked, want.read_data, want.int_n, rsp.read_data, rsp.int_n);
				end
			end
			n_checked++;
		end
	end

	initial begin
		int kind;
		int directed;
		logic [7:0] cfg;

		// directed: reset status, id registers, period of one, status clear,
		// full data stream, write with no start advancing the pointer
		push_event(OP_READ, 8'h00);
		select_reg(REG_PART_ID);
		read_bytes(1);
		select_reg(REG_REV_ID);
		read_bytes(1);
		select_reg(REG_FIFO_CFG);
		push_event(OP_WRITE, 8'h00);
		push_event(OP_WRITE, 8'hFF);
		push_event(OP_TICK, 8'hFF);
		push_event(OP_TICK, 8'h00);
		select_reg(REG_STATUS);
		read_bytes(2);
		select_reg(REG_DATA);
		read_bytes(6);
		push_event(OP_WRITE, 8'h01);
		read_bytes(1);
		directed = event_queue.size();

		while (event_queue.size() < directed + RANDOM_EVENTS) begin
			kind = $urandom_range(0, 99);
			if (kind < 30) begin
				repeat ($urandom_range(1, 12)) push_event(OP_TICK, 8'($urandom));
			end else if (kind < 55) begin
				cfg = pick_reg();
				select_reg(cfg);
				if (cfg == REG_DATA)
					read_bytes($urandom_range(0, 3) == 0 ? $urandom_range(1, 5) : 6);
				else
					read_bytes($urandom_range(1, 3));
			end else if (kind < 70) begin
				select_reg(REG_FIFO_CFG);
				cfg = $urandom_range(0, 3) == 0 ? 8'($urandom)
					: {3'($urandom_range(0, 2)), 5'($urandom)};
				push_event(OP_WRITE, cfg);
				if ($urandom_range(0, 3) == 0)
					push_event(OP_WRITE, 8'($urandom));
			end else if (kind < 80) begin
				select_reg(REG_STATUS);
				read_bytes(1);
			end else if (kind < 90) begin
				select_reg($urandom_range(0, 2) == 0 ? 8'($urandom_range(8'hFD, 8'hFF)) : pick_reg());
				repeat ($urandom_range(1, 3)) push_event(OP_WRITE, 8'($urandom));
				if ($urandom_range(0, 1) == 0)
					read_bytes(1);
			end else begin
				repeat ($urandom_range(1, 4)) push_event(op_t'($urandom_range(0, 3)), 8'($urandom));
			end
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		while (event_queue.size() > 0 || req.valid)
			@(posedge clk);
		while (rsp_expected.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d bus events sent, %0d responses checked, %0d mismatches", n_sent, n_checked,
			errors);
		$display("%0d sample events, %0d waveform bytes read, one long output hold-off",
			n_samples, n_stream_bytes);
		if (errors == 0 && rsp_expected.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule

FILE: sim.f
hw/rtl/ppg_pkg.sv
hw/rtl/ppg_req_if.sv
hw/rtl/ppg_rsp_if.sv
hw/rtl/ppg_ctrl.sv
hw/rtl/ppg_dp.sv
hw/rtl/ppg_sensor_register_model.sv
sim/tb_ppg_sensor_register_model.sv
